FILE: sv/cec_pkg.sv
// cec_pkg: shared types and constants for the case escape codec
// holds the result and bundle types passed from front end through queue to back end
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cec_pkg;

  localparam int CP_W      = 21;
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] CFG_DIRECTION     = 2'd0;
  localparam logic [1:0] CFG_SINGLE_ESCAPE = 2'd1;
  localparam logic [1:0] CFG_SPAN_ESCAPE   = 2'd2;

  localparam logic [CP_W-1:0] SINGLE_ESC_RST = CP_W'(95);
  localparam logic [CP_W-1:0] SPAN_ESC_RST   = CP_W'(164);

  typedef struct packed {
    logic [CP_W-1:0] ch;
    logic            char_valid;
    logic            status;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]  cnt;
  } bundle_t;

endpackage

`default_nettype wire

FILE: sv/case_escape_codec.sv
// case_escape_codec: streaming case codec with single and span escapes
// top level joining cec_front, cec_queue and cec_back; uses cec_pkg
//
//   port group  direction  handshake            payload
//   in_         input      in_valid / in_stall   in_code_point, in_end_of_stream
//   out_        output     out_valid / out_stall out_char, out_char_valid, out_last, out_status
//   cfg_        input      cfg_we                cfg_index, cfg_wdata
//
// one result leaves per cycle while out_stall is low; an item gives zero to four results,
// so items with at most one result go through at one per cycle; longer ones can fill the queue
// a two-entry bundle queue sits between the phase machine and the output register
// results go via the queue to the output register; in_stall is high while the queue is full
// synchronous reset clears phase, queue and output valid; escapes return to 95 and 164
`timescale 1ns / 1ps
`default_nettype none

module case_escape_codec import cec_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [CP_W-1:0] cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [CP_W-1:0] in_code_point,
  input  wire logic            in_end_of_stream,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [CP_W-1:0]      out_char,
  output logic                 out_char_valid,
  output logic                 out_last,
  output logic                 out_status
);

  bundle_t fe_bundle, q_head;
  logic    fe_push, q_pop, q_not_empty, q_full, acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  cec_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .acc           (acc),
    .code_point    (in_code_point),
    .end_of_stream (in_end_of_stream),
    .bundle        (fe_bundle),
    .push          (fe_push)
  );

  cec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_push),
    .wr_data   (fe_bundle),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  cec_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .not_empty      (q_not_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

FILE: sv/cec_front.sv
// cec_front: configuration registers, phase machine and lookahead character
// turns each accepted input into a bundle of up to four results; uses cec_pkg
`timescale 1ns / 1ps
`default_nettype none

module cec_front import cec_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [CP_W-1:0] cfg_wdata,
  input  wire logic            acc,
  input  wire logic [CP_W-1:0] code_point,
  input  wire logic            end_of_stream,
  output bundle_t              bundle,
  output logic                 push
);

  localparam logic [2:0] PH_START      = 3'd0;
  localparam logic [2:0] D_AFTER_ESC   = 3'd1;
  localparam logic [2:0] D_SPAN_START  = 3'd2;
  localparam logic [2:0] D_SPAN_BODY   = 3'd3;
  localparam logic [2:0] D_SPAN_ESC    = 3'd4;
  localparam logic [2:0] E_HELD        = 3'd1;
  localparam logic [2:0] E_SPAN        = 3'd2;

  localparam logic [CP_W-1:0] CASE_OFS = CP_W'(32);

  logic            dir_r;
  logic [CP_W-1:0] sgl_r;
  logic [CP_W-1:0] span_r;
  logic [2:0]      phase_r, phase_nxt;
  logic [CP_W-1:0] held_r, held_nxt;

  logic [CP_W-1:0] ch [MAX_RES];
  logic [RES_CNT_W-1:0] n;
  logic            st;
  logic            c_up, c_low, c_sgl, c_span;
  logic [CP_W-1:0] c_lower, c_upper;
  logic [CP_W-1:0] es0, es1;
  logic [RES_CNT_W-1:0] es_n;
  logic [2:0]      es_ph;

  assign c_up    = (code_point >= CP_W'(65)) && (code_point <= CP_W'(90));
  assign c_low   = (code_point >= CP_W'(97)) && (code_point <= CP_W'(122));
  assign c_sgl   = (code_point == sgl_r);
  assign c_span  = (code_point == span_r);
  assign c_lower = c_up ? code_point + CASE_OFS : code_point;
  assign c_upper = c_low ? code_point - CASE_OFS : code_point;

  // span continuation of the encoder
  always_comb begin
    priority if (c_span) begin
      es0 = span_r; es1 = span_r; es_n = RES_CNT_W'(2); es_ph = E_SPAN;
    end else if (c_low) begin
      es0 = span_r; es1 = c_upper; es_n = RES_CNT_W'(2); es_ph = PH_START;
    end else begin
      es0 = code_point; es1 = code_point; es_n = RES_CNT_W'(1); es_ph = E_SPAN;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_RES; k++) ch[k] = '0;
    n         = '0;
    st        = 1'b0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (end_of_stream) begin
      phase_nxt = PH_START;
      if (!dir_r) begin
        if (phase_r == D_AFTER_ESC) begin
          ch[0] = sgl_r; n = RES_CNT_W'(1);
        end else if (phase_r == D_SPAN_START || phase_r == D_SPAN_BODY) begin
          st = 1'b1;
        end
      end else begin
        if (phase_r == E_HELD) begin
          ch[0] = sgl_r; ch[1] = held_r; n = RES_CNT_W'(2);
        end else if (phase_r == E_SPAN) begin
          ch[0] = span_r; n = RES_CNT_W'(1);
        end
      end
    end else if (!dir_r) begin
      unique case (phase_r)
        D_AFTER_ESC: begin
          if (c_span) begin
            ch[0] = sgl_r; n = RES_CNT_W'(1); phase_nxt = D_SPAN_START;
          end else begin
            ch[0] = code_point; n = RES_CNT_W'(1); phase_nxt = PH_START;
          end
        end
        D_SPAN_START: begin
          ch[0] = code_point; n = RES_CNT_W'(1);
          phase_nxt = c_span ? PH_START : D_SPAN_BODY;
        end
        D_SPAN_BODY: begin
          if (c_span) begin
            phase_nxt = D_SPAN_ESC;
          end else begin
            ch[0] = code_point; n = RES_CNT_W'(1);
          end
        end
        D_SPAN_ESC: begin
          priority if (c_span) begin
            ch[0] = span_r; n = RES_CNT_W'(1); phase_nxt = D_SPAN_BODY;
          end else if (c_sgl) begin
            phase_nxt = D_AFTER_ESC;
          end else begin
            ch[0] = c_lower; n = RES_CNT_W'(1); phase_nxt = PH_START;
          end
        end
        default: begin
          priority if (c_sgl) begin
            phase_nxt = D_AFTER_ESC;
          end else if (c_span) begin
            phase_nxt = D_SPAN_START;
          end else begin
            ch[0] = c_lower; n = RES_CNT_W'(1); phase_nxt = PH_START;
          end
        end
      endcase
    end else begin
      unique case (phase_r)
        E_HELD: begin
          if (c_sgl || c_span || c_up) begin
            ch[0] = span_r; ch[1] = held_r; ch[2] = es0; ch[3] = es1;
            n = es_n + RES_CNT_W'(2); phase_nxt = es_ph;
          end else begin
            ch[0] = sgl_r; ch[1] = held_r; ch[2] = c_upper;
            n = RES_CNT_W'(3); phase_nxt = PH_START;
          end
        end
        E_SPAN: begin
          ch[0] = es0; ch[1] = es1; n = es_n; phase_nxt = es_ph;
        end
        default: begin
          priority if (c_span) begin
            ch[0] = span_r; ch[1] = span_r; n = RES_CNT_W'(2); phase_nxt = PH_START;
          end else if (!c_sgl && !c_up) begin
            ch[0] = c_upper; n = RES_CNT_W'(1); phase_nxt = PH_START;
          end else begin
            held_nxt = code_point; phase_nxt = E_HELD;
          end
        end
      endcase
    end
  end

  // pack the results, end item after the characters
  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      bundle.res[k].ch         = ch[k];
      bundle.res[k].char_valid = 1'b1;
      bundle.res[k].status     = 1'b0;
      if (end_of_stream && (RES_CNT_W'(k) == n)) begin
        bundle.res[k].ch         = '0;
        bundle.res[k].char_valid = 1'b0;
        bundle.res[k].status     = st;
      end
    end
    bundle.cnt = end_of_stream ? n + RES_CNT_W'(1) : n;
  end

  assign push = acc && (bundle.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      sgl_r   <= SINGLE_ESC_RST;
      span_r  <= SPAN_ESC_RST;
      phase_r <= PH_START;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: begin
          dir_r   <= cfg_wdata[0];
          phase_r <= PH_START;
        end
        CFG_SINGLE_ESCAPE: sgl_r  <= cfg_wdata;
        CFG_SPAN_ESCAPE:   span_r <= cfg_wdata;
        default: ;
      endcase
    end else if (acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cec_queue.sv
// cec_queue: small register queue of result bundles between front and back end
// depends on cec_pkg for the bundle type and depth
`timescale 1ns / 1ps
`default_nettype none

module cec_queue import cec_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t wr_data,
  input  wire logic    pop,
  output bundle_t      head,
  output logic         not_empty,
  output logic         full
);

  bundle_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + Q_CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cec_back.sv
// cec_back: walks the head bundle one result per cycle, while the output is not stalled, into the output register
// depends on cec_pkg for the bundle type
`timescale 1ns / 1ps
`default_nettype none

module cec_back import cec_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bundle_t    head,
  input  wire logic       not_empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [CP_W-1:0] out_char,
  output logic            out_char_valid,
  output logic            out_last,
  output logic            out_status
);

  logic [RES_IDX_W-1:0] idx_r;
  logic                 valid_r;
  logic [CP_W-1:0]      char_r;
  logic                 cv_r, last_r, status_r;
  logic                 adv, take, is_last;
  result_t              cur;

  assign adv     = !valid_r || !out_stall;
  assign take    = adv && not_empty;
  assign cur     = head.res[idx_r];
  assign is_last = ({1'b0, idx_r} == head.cnt - RES_CNT_W'(1));
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (adv) begin
      valid_r <= not_empty;
      if (take) idx_r <= is_last ? '0 : idx_r + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      char_r   <= cur.ch;
      cv_r     <= cur.char_valid;
      status_r <= cur.status;
      last_r   <= is_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_char       = char_r;
  assign out_char_valid = cv_r;
  assign out_last       = last_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire

FILE: dv/tb_case_escape_codec.sv
`timescale 1ns / 1ps
// tb_case_escape_codec: self-checking bench for the case escape codec, both directions
// predicts the results of each input transfer and checks them in order under random idling
// depends on cec_pkg and case_escape_codec

module tb_case_escape_codec;
  import cec_pkg::*;

  localparam logic [1:0]      CFG_RESERVED  = 2'd3;
  localparam logic [CP_W-1:0] CP_MAX        = {CP_W{1'b1}};
  localparam int              CYCLE_LIMIT   = 200000;
  localparam int              SETTLE_CYCLES = 6;
  localparam int unsigned     EOS_MARK      = 32'hFFFF_FFFF;

  localparam logic [2:0] DEC_IDLE       = 3'd0;
  localparam logic [2:0] DEC_AFTER_ESC  = 3'd1;
  localparam logic [2:0] DEC_SPAN_OPEN  = 3'd2;
  localparam logic [2:0] DEC_IN_SPAN    = 3'd3;
  localparam logic [2:0] DEC_SPAN_CLOSE = 3'd4;
  localparam logic [2:0] ENC_IDLE       = 3'd0;
  localparam logic [2:0] ENC_HELD       = 3'd1;
  localparam logic [2:0] ENC_SPAN       = 3'd2;

  typedef struct packed {
    logic [CP_W-1:0] ch;
    logic            char_valid;
    logic            last;
    logic            status;
  } codec_res_t;

  logic            clk              = 1'b0;
  logic            rst_n            = 1'b0;
  logic            cfg_we           = 1'b0;
  logic [1:0]      cfg_index        = CFG_DIRECTION;
  logic [CP_W-1:0] cfg_wdata        = '0;
  logic            in_valid         = 1'b0;
  logic            in_stall;
  logic [CP_W-1:0] in_code_point    = '0;
  logic            in_end_of_stream = 1'b0;
  logic            out_valid;
  logic            out_stall        = 1'b0;
  logic [CP_W-1:0] out_char;
  logic            out_char_valid;
  logic            out_last;
  logic            out_status;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int errors         = 0;
  int items_sent     = 0;
  int eos_sent       = 0;
  int results_seen   = 0;

  // codec state as predicted
  logic            m_dir    = 1'b0;
  logic [CP_W-1:0] m_single = SINGLE_ESC_RST;
  logic [CP_W-1:0] m_span   = SPAN_ESC_RST;
  logic [CP_W-1:0] m_held   = '0;
  logic [2:0]      m_phase  = DEC_IDLE;

  logic [CP_W-1:0] emit_q[$];
  codec_res_t      expected_results[$];

  case_escape_codec uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_code_point    (in_code_point),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_char_valid   (out_char_valid),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  function automatic logic is_upper(logic [CP_W-1:0] c);
    return c >= CP_W'('h41) && c <= CP_W'('h5A);
  endfunction

  function automatic logic is_lower(logic [CP_W-1:0] c);
    return c >= CP_W'('h61) && c <= CP_W'('h7A);
  endfunction

  function automatic logic [CP_W-1:0] upcase(logic [CP_W-1:0] c);
    return is_lower(c) ? c - CP_W'('h20) : c;
  endfunction

  function automatic logic [CP_W-1:0] downcase(logic [CP_W-1:0] c);
    return is_upper(c) ? c + CP_W'('h20) : c;
  endfunction

  function automatic void dec_from_idle(logic [CP_W-1:0] c);
    if (c == m_single) begin
      m_phase = DEC_AFTER_ESC;
    end else if (c == m_span) begin
      m_phase = DEC_SPAN_OPEN;
    end else begin
      emit_q.push_back(downcase(c));
      m_phase = DEC_IDLE;
    end
  endfunction

  function automatic void dec_char(logic [CP_W-1:0] c);
    case (m_phase)
      DEC_AFTER_ESC: begin
        if (c == m_span) begin
          emit_q.push_back(m_single);
          m_phase = DEC_SPAN_OPEN;
        end else begin
          emit_q.push_back(c);
          m_phase = DEC_IDLE;
        end
      end
      DEC_SPAN_OPEN: begin
        emit_q.push_back(c);
        m_phase = (c == m_span) ? DEC_IDLE : DEC_IN_SPAN;
      end
      DEC_IN_SPAN: begin
        if (c == m_span) m_phase = DEC_SPAN_CLOSE;
        else emit_q.push_back(c);
      end
      DEC_SPAN_CLOSE: begin
        if (c == m_span) begin
          emit_q.push_back(m_span);
          m_phase = DEC_IN_SPAN;
        end else begin
          dec_from_idle(c);
        end
      end
      default: dec_from_idle(c);
    endcase
  endfunction

  function automatic void enc_in_span(logic [CP_W-1:0] c);
    if (c == m_span) begin
      emit_q.push_back(m_span);
      emit_q.push_back(m_span);
      m_phase = ENC_SPAN;
    end else if (is_lower(c)) begin
      emit_q.push_back(m_span);
      emit_q.push_back(upcase(c));
      m_phase = ENC_IDLE;
    end else begin
      emit_q.push_back(c);
      m_phase = ENC_SPAN;
    end
  endfunction

  function automatic void enc_char(logic [CP_W-1:0] c);
    case (m_phase)
      ENC_HELD: begin
        if (c == m_single || c == m_span || is_upper(c)) begin
          emit_q.push_back(m_span);
          emit_q.push_back(m_held);
          enc_in_span(c);
        end else begin
          emit_q.push_back(m_single);
          emit_q.push_back(m_held);
          emit_q.push_back(upcase(c));
          m_phase = ENC_IDLE;
        end
      end
      ENC_SPAN: enc_in_span(c);
      default: begin
        if (c == m_span) begin
          emit_q.push_back(m_span);
          emit_q.push_back(m_span);
          m_phase = ENC_IDLE;
        end else if (c != m_single && !is_upper(c)) begin
          emit_q.push_back(upcase(c));
          m_phase = ENC_IDLE;
        end else begin
          m_held  = c;
          m_phase = ENC_HELD;
        end
      end
    endcase
  endfunction

  function automatic void predict_codec(logic [CP_W-1:0] cp, logic eos);
    logic st;
    int   n;
    st = 1'b0;
    emit_q.delete();
    if (eos) begin
      if (!m_dir) begin
        if (m_phase == DEC_AFTER_ESC) emit_q.push_back(m_single);
        else if (m_phase == DEC_SPAN_OPEN || m_phase == DEC_IN_SPAN) st = 1'b1;
      end else begin
        if (m_phase == ENC_HELD) begin
          emit_q.push_back(m_single);
          emit_q.push_back(m_held);
        end else if (m_phase == ENC_SPAN) begin
          emit_q.push_back(m_span);
        end
      end
      m_phase = DEC_IDLE;
    end else if (!m_dir) begin
      dec_char(cp);
    end else begin
      enc_char(cp);
    end
    n = emit_q.size();
    foreach (emit_q[k])
      expected_results.push_back('{ch: emit_q[k], char_valid: 1'b1,
                                   last: !eos && k == n - 1, status: 1'b0});
    if (eos)
      expected_results.push_back('{ch: '0, char_valid: 1'b0, last: 1'b1, status: st});
  endfunction

  function automatic logic [CP_W-1:0] random_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 28) return CP_W'('h61 + $urandom_range(25));
    if (r < 52) return CP_W'('h41 + $urandom_range(25));
    if (r < 64) return m_single;
    if (r < 78) return m_span;
    if (r < 92) return CP_W'($urandom_range('h7E, 'h20));
    return CP_W'($urandom_range(CP_MAX));
  endfunction

  function automatic logic [CP_W-1:0] random_escape();
    case ($urandom_range(5))
      0: return SINGLE_ESC_RST;
      1: return SPAN_ESC_RST;
      2: return CP_W'('h41 + $urandom_range(57));
      3: return CP_W'($urandom_range('h7E, 'h20));
      4: return $urandom_range(1) ? CP_MAX : '0;
      default: return CP_W'($urandom_range(CP_MAX));
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [CP_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DIRECTION: begin
        m_dir   = data[0];
        m_phase = DEC_IDLE;
      end
      CFG_SINGLE_ESCAPE: m_single = data;
      CFG_SPAN_ESCAPE:   m_span   = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic [CP_W-1:0] cp, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_code_point    <= cp;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_codec(cp, eos);
    items_sent++;
    if (eos) eos_sent++;
  endtask

  task automatic send_text(input int unsigned seq[$]);
    foreach (seq[i]) begin
      if (seq[i] == EOS_MARK) send_item(CP_W'($urandom_range(CP_MAX)), 1'b1);
      else send_item(seq[i][CP_W-1:0], 1'b0);
    end
  endtask

  task automatic test_decode_basics();
    int unsigned seq[$];
    // reset escapes; escaped letter, escape before span, doubled span escape, open span at end
    seq = '{'h48, 0, CP_MAX, SINGLE_ESC_RST, 'h41, SINGLE_ESC_RST, SPAN_ESC_RST, 'h78,
            SPAN_ESC_RST, SPAN_ESC_RST, 'h5A, EOS_MARK, SINGLE_ESC_RST, EOS_MARK,
            SPAN_ESC_RST, 'h61, SPAN_ESC_RST, EOS_MARK};
    send_text(seq);
  endtask

  task automatic test_encode_basics();
    int unsigned seq[$];
    wait_drained();
    write_reg(CFG_DIRECTION, CP_W'(1));
    // uppercase runs become spans; held character flushed at end
    seq = '{0, 'h61, 'h42, 'h43, 'h64, 'h51, 'h72, SINGLE_ESC_RST, SPAN_ESC_RST, 'h45,
            EOS_MARK, 'h5A, EOS_MARK};
    send_text(seq);
  endtask

  task automatic test_equal_escapes();
    int unsigned seq[$];
    wait_drained();
    write_reg(CFG_DIRECTION, CP_W'(0));
    seq = '{SINGLE_ESC_RST};
    send_text(seq);
    // escape writes while mid-escape keep the phase
    wait_drained();
    write_reg(CFG_SINGLE_ESCAPE, CP_W'('h23));
    write_reg(CFG_SPAN_ESCAPE, CP_W'('h23));
    write_reg(CFG_RESERVED, CP_W'('h41));
    seq = '{'h23, 'h61, 'h23, 'h61, 'h23, EOS_MARK};
    send_text(seq);
    wait_drained();
    write_reg(CFG_DIRECTION, CP_W'(1));
    seq = '{'h23, 'h6B, EOS_MARK};
    send_text(seq);
  endtask

  task automatic test_random_streams();
    logic [CP_W-1:0] esc_a;
    logic [CP_W-1:0] esc_b;
    for (int mode = 0; mode < 4; mode++) begin
      for (int d = 0; d < 2; d++) begin
        wait_drained();
        case (mode)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
          default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
        write_reg(CFG_DIRECTION, CP_W'(($urandom_range(CP_MAX) & ~32'd1) | 32'(d)));
        if (mode == 0) begin
          esc_a = d ? CP_MAX : '0;
          esc_b = d ? '0 : CP_MAX;
        end else begin
          esc_a = random_escape();
          esc_b = random_escape();
        end
        write_reg(CFG_SINGLE_ESCAPE, esc_a);
        write_reg(CFG_SPAN_ESCAPE, esc_b);
        if ($urandom_range(3) == 0) write_reg(CFG_RESERVED, CP_W'($urandom_range(CP_MAX)));
        for (int i = 0; i < 9; i++) begin
          if (mode == 3 && d == 0 && i == 7) wait_drained();
          if ($urandom_range(9) == 0) send_item(CP_W'($urandom_range(CP_MAX)), 1'b1);
          else send_item(random_char(), 1'b0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    codec_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result char %h valid %b last %b status %b",
                 $time, out_char, out_char_valid, out_last, out_status);
      end else begin
        want = expected_results.pop_front();
        if (out_char !== want.ch || out_char_valid !== want.char_valid ||
            out_last !== want.last || out_status !== want.status) begin
          errors++;
          $display("%0t: expected char %h valid %b last %b status %b, got %h %b %b %b",
                   $time, want.ch, want.char_valid, want.last, want.status,
                   out_char, out_char_valid, out_last, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_decode_basics();
    test_encode_basics();
    test_equal_escapes();
    test_random_streams();
    wait_drained();
    $display("covered %0d input transfers, %0d of them end of stream, and %0d results",
             items_sent, eos_sent, results_seen);
    $display("both directions with reset, equal, extreme and random escapes, four idling mixes");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cec_pkg.sv
sv/cec_front.sv
sv/cec_queue.sv
sv/cec_back.sv
sv/case_escape_codec.sv
dv/tb_case_escape_codec.sv
